FILE: rtl/zcp_pkg.sv
`default_nettype none

package zcp_pkg;

    localparam int COORD_BITS    = 16;
    localparam int KEY_BITS      = 2 * COORD_BITS + 1;
    localparam int SUM_BITS      = COORD_BITS + 1;
    localparam int CAND_BITS     = KEY_BITS + 1;
    localparam int PROD_BITS     = 2 * SUM_BITS;
    localparam int SEARCH_STAGES = COORD_BITS + 1;
    localparam int IN_TDATA_BITS  = ((2 * COORD_BITS + KEY_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((KEY_BITS + 2 * COORD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [SUM_BITS-1:0]   sum_t;

    typedef enum logic {
        OP_PAIR   = 1'b0,
        OP_UNPAIR = 1'b1
    } opcode_t;

    // one pipeline slot: pair path uses psum/pkey, unpair path uses s/tnum
    typedef struct packed {
        opcode_t op;
        key_t    key;
        coord_t  ex;
        coord_t  ez;
        sum_t    psum;
        key_t    pkey;
        sum_t    s;
        key_t    tnum;
    } stage_t;

    typedef struct packed {
        key_t   key;
        coord_t x;
        coord_t z;
        logic   err;
    } result_t;

    function automatic coord_t zigzag(coord_t v);
        return {v[COORD_BITS-2:0], 1'b0} ^ {COORD_BITS{v[COORD_BITS-1]}};
    endfunction

    function automatic coord_t unzigzag(coord_t m);
        return {1'b0, m[COORD_BITS-1:1]} ^ {COORD_BITS{m[0]}};
    endfunction

    // triangular number of 2^b
    function automatic logic [CAND_BITS-1:0] tri_pow2(int b);
        logic [CAND_BITS-1:0] p;
        p = CAND_BITS'(1) << b;
        if (b == 0) begin
            return CAND_BITS'(1);
        end
        return (p >> 1) * (p + CAND_BITS'(1));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/zigzag_cantor_pair_unpair_unit.sv
`default_nettype none

// Channel   Dir  tvalid/tready  tdata (low bit up)                  tuser
// s_        in   s_tvalid/rdy   coord_x[15:0] coord_z[31:16]        opcode (0 pair, 1 unpair)
//                               key_in[64:32], zero pad to 72
// m_        out  m_tvalid/rdy   key_out[32:0] x_out[48:33]          range_error
//                               z_out[64:49], zero pad to 72
//
// One transfer per cycle in and out while m_ is not stalled. The pipe holds:
// one input stage, COORD_BITS + 1 root-search stages (one root bit each), output register.
// The pair path (sum, triangular number, add) rides the first search stages.
// aresetn clears only valid bits; payload registers are not reset.
// A stall on m_ freezes the whole pipe; s_tready drops only while the output is full and
// not taken, so nothing is lost or repeated.
module zigzag_cantor_pair_unpair_unit (
    input  var logic                                 aclk,
    input  var logic                                 aresetn,

    input  var logic                                 s_tvalid,
    output logic                                     s_tready,
    // coord_x, coord_z, key_in, zero pad
    input  var logic [zcp_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // opcode
    input  var logic                                 s_tuser,

    output logic                                     m_tvalid,
    input  var logic                                 m_tready,
    // key_out, x_out, z_out, zero pad
    output logic [zcp_pkg::OUT_TDATA_BITS-1:0]       m_tdata,
    // range_error
    output logic                                     m_tuser
);

    localparam int S = zcp_pkg::SEARCH_STAGES;

    zcp_pkg::stage_t  pipe_reg   [0:S];
    zcp_pkg::stage_t  pipe_next  [0:S];
    logic [S:0]       vld_reg;
    logic [S:0]       vld_next;
    zcp_pkg::result_t out_reg;
    zcp_pkg::result_t out_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             pipe_en;

    // whole pipe advances unless the output holds a result that is not taken
    assign pipe_en  = !out_vld_reg || m_tready;
    assign s_tready = pipe_en;

    // input stage: zigzag both coordinates up front
    always_comb begin
        pipe_next[0]      = '0;
        pipe_next[0].op   = zcp_pkg::opcode_t'(s_tuser);
        pipe_next[0].ex   = zcp_pkg::zigzag(s_tdata[zcp_pkg::COORD_BITS-1:0]);
        pipe_next[0].ez   = zcp_pkg::zigzag(s_tdata[2*zcp_pkg::COORD_BITS-1:zcp_pkg::COORD_BITS]);
        pipe_next[0].key  = s_tdata[2*zcp_pkg::COORD_BITS+zcp_pkg::KEY_BITS-1:
                                    2*zcp_pkg::COORD_BITS];
    end

    // search stage k decides root bit COORD_BITS+1-k:
    //   T(s | 2^b) = T(s) + (s << b) + T(2^b), since s has no bits at or below b
    genvar k;
    generate
        for (k = 1; k <= S; k++) begin : gen_stage
            localparam int BPOS = zcp_pkg::COORD_BITS + 1 - k;
            localparam logic [zcp_pkg::CAND_BITS-1:0] TRI_B = zcp_pkg::tri_pow2(BPOS);

            logic [zcp_pkg::CAND_BITS-1:0] cand;
            logic [zcp_pkg::PROD_BITS-1:0] prod;

            assign cand = zcp_pkg::CAND_BITS'(pipe_reg[k-1].tnum)
                        + (zcp_pkg::CAND_BITS'(pipe_reg[k-1].s) << BPOS) + TRI_B;
            assign prod = zcp_pkg::PROD_BITS'(pipe_reg[k-1].psum)
                        * (zcp_pkg::PROD_BITS'(pipe_reg[k-1].psum) + zcp_pkg::PROD_BITS'(1));

            always_comb begin
                pipe_next[k] = pipe_reg[k-1];
                if (cand <= zcp_pkg::CAND_BITS'(pipe_reg[k-1].key)) begin
                    pipe_next[k].s    = pipe_reg[k-1].s | (zcp_pkg::SUM_BITS'(1) << BPOS);
                    pipe_next[k].tnum = cand[zcp_pkg::KEY_BITS-1:0];
                end
                // pair path: sum, triangular number, add ez
                if (k == 1) begin
                    pipe_next[k].psum = zcp_pkg::SUM_BITS'(pipe_reg[k-1].ex)
                                      + zcp_pkg::SUM_BITS'(pipe_reg[k-1].ez);
                end
                if (k == 2) begin
                    pipe_next[k].pkey = prod[zcp_pkg::KEY_BITS:1];
                end
                if (k == 3) begin
                    pipe_next[k].pkey = pipe_reg[k-1].pkey
                                      + zcp_pkg::KEY_BITS'(pipe_reg[k-1].ez);
                end
            end
        end
    endgenerate

    zcp_finish u_finish (
        .stage_i  (pipe_reg[S]),
        .result_o (out_next)
    );

    assign vld_next     = {vld_reg[S-1:0], s_tvalid};
    assign out_vld_next = vld_reg[S];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pipe_reg <= pipe_next;
            out_reg  <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = zcp_pkg::OUT_TDATA_BITS'({out_reg.z, out_reg.x, out_reg.key});
    assign m_tuser  = out_reg.err;

`ifndef SYNTHESIS
    // a flagged unpair carries all-zero payload
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_reg.err |->
            out_reg.key == '0 && out_reg.x == '0 && out_reg.z == '0)
        else $error("flagged result with nonzero payload");

    // root search never overshoots the key
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S] && pipe_reg[S].op == zcp_pkg::OP_UNPAIR |->
            pipe_reg[S].tnum <= pipe_reg[S].key)
        else $error("root search exceeded key");

    // stalled pipe keeps its occupancy
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_reg) && $stable(out_vld_reg))
        else $error("pipe moved during stall");
`endif

endmodule

`default_nettype wire

FILE: rtl/zcp_finish.sv
`default_nettype none

// Last step: remainder of the root search gives ez, then ex; range check and unzigzag.
module zcp_finish (
    input  var zcp_pkg::stage_t  stage_i,
    output zcp_pkg::result_t     result_o
);

    zcp_pkg::key_t ez;
    zcp_pkg::key_t ex;
    logic          err;

    assign ez  = stage_i.key - stage_i.tnum;
    assign ex  = zcp_pkg::KEY_BITS'(stage_i.s) - ez;
    assign err = ((ex >> zcp_pkg::COORD_BITS) != '0) || ((ez >> zcp_pkg::COORD_BITS) != '0);

    always_comb begin
        result_o = '0;
        if (stage_i.op == zcp_pkg::OP_UNPAIR) begin
            result_o.err = err;
            if (!err) begin
                result_o.x = zcp_pkg::unzigzag(ex[zcp_pkg::COORD_BITS-1:0]);
                result_o.z = zcp_pkg::unzigzag(ez[zcp_pkg::COORD_BITS-1:0]);
            end
        end else begin
            result_o.key = stage_i.pkey;
        end
    end

endmodule

`default_nettype wire
